[hw/rtl/cle_pkg.sv]
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants of the canonical line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int unsigned RingDepthDefault = 256;

  localparam logic [7:0] ByteBs     = 8'h08;
  localparam logic [7:0] ByteIntr   = 8'h03;
  localparam logic [7:0] ByteEof    = 8'h04;
  localparam logic [7:0] ByteKill   = 8'h15;
  localparam logic [7:0] ByteWerase = 8'h17;
  localparam logic [7:0] ByteDel    = 8'h7f;
  localparam logic [7:0] ByteLf     = 8'h0a;
  localparam logic [7:0] ByteCr     = 8'h0d;
  localparam logic [7:0] ByteTab    = 8'h09;
  localparam logic [7:0] ByteSpace  = 8'h20;
  localparam logic [7:0] ByteBell   = 8'h07;
  localparam logic [7:0] ByteCaret  = 8'h5e;
  localparam logic [7:0] ByteQmark  = 8'h3f;
  localparam logic [7:0] CaretOfs   = 8'h40;
  localparam logic [8:0] ColsMax    = 9'd511;

  localparam logic [1:0] CfgCanon = 2'd0;
  localparam logic [1:0] CfgEcho  = 2'd1;
  localparam logic [1:0] CfgCtrl  = 2'd2;

  typedef enum logic [2:0] {
    KindEcho  = 3'd0,
    KindErase = 3'd1,
    KindRead  = 3'd2,
    KindEmpty = 3'd3,
    KindEof   = 3'd4,
    KindStat  = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    StIdle,
    StRdWait,
    StEraseChk,
    StEcho1,
    StEcho2,
    StEcho3,
    StEcho4,
    StEraseOut,
    StStatus
  } state_e;

  typedef enum logic [1:0] {
    ErOne,
    ErKill,
    ErWordBlank,
    ErWordText
  } erase_e;

  function automatic logic is_ctrl(input logic [7:0] c);
    return (c < ByteSpace && c != ByteTab) || c == ByteDel;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == ByteSpace || c == ByteTab;
  endfunction

endpackage

[hw/rtl/canonical_line_editor_top.sv]
// ----------------------------------------------------------------------------
// canonical_line_editor_top
// Terminal line discipline on a ring store with read, commit, write pointers.
// ----------------------------------------------------------------------------
// One item at a time; the receiver cannot stall. A read of a byte passes
// through StRdWait to StStatus, an empty or end-of-file read goes straight to
// StStatus. A put goes through StEcho1, which sends one echo beat per visit,
// to StStatus. An erase walks down in StEraseChk, which tests one byte per
// visit while the RAM read of the next byte down is issued, and closes the
// walk in StEraseOut, in which the erase beat goes out; a word erase that
// stops on a blank also tests that blank. Results come out one per cycle
// marked by result_valid_o and must be taken at once; busy_o stays high until
// the last beat of the item has gone out. No clearing pass after reset.
module canonical_line_editor_top #(
  parameter int unsigned RingDepth = cle_pkg::RingDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 action_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output logic                 result_valid_o,
  output logic [2:0]           kind_o,
  output logic [7:0]           out_byte_o,
  output logic [8:0]           erase_columns_o,
  output logic                 accepted_o,
  output logic                 wake_reader_o,
  output logic [7:0]           lines_ready_o,
  output logic                 last_o
);

  import cle_pkg::*;

  localparam int unsigned Aw = $clog2(RingDepth);
  localparam logic [Aw-1:0] PtrMax = Aw'(RingDepth - 1);

  state_e state_q, state_d;
  erase_e emode_q, emode_d;
  logic [Aw-1:0] wp_q, wp_d, rp_q, rp_d, cp_q, cp_d;
  logic eof_q, eof_d;
  logic [7:0] lc_q, lc_d;
  logic canon_q, echo_q, ctrl_q;
  logic [7:0] c_q, c_d;
  logic [7:0] e1_q, e1_d, e2_q, e2_d;
  logic [2:0] necho_q, necho_d;
  logic [8:0] cols_q, cols_d;
  logic acc_q, acc_d, wake_q, wake_d, intr_q, intr_d, isrd_q, isrd_d;
  logic [7:0] rb_q, rb_d;

  logic mem_we;
  logic [Aw-1:0] mem_addr;
  logic [7:0] mem_wdata, mem_rdata;

  cle_ram #(.Width(8), .Depth(RingDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  function automatic logic [Aw-1:0] nxt(input logic [Aw-1:0] p);
    return (p == PtrMax) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [Aw-1:0] prv(input logic [Aw-1:0] p);
    return (p == '0) ? PtrMax : p - 1'b1;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canon_q <= 1'b1;
      echo_q  <= 1'b1;
      ctrl_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgCanon: canon_q <= cfg_data_i[0];
        CfgEcho:  echo_q  <= cfg_data_i[0];
        CfgCtrl:  ctrl_q  <= cfg_data_i[0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wp_q <= '0;
      rp_q <= '0;
      cp_q <= '0;
      eof_q <= 1'b0;
      lc_q <= '0;
    end else begin
      state_q <= state_d;
      wp_q <= wp_d;
      rp_q <= rp_d;
      cp_q <= cp_d;
      eof_q <= eof_d;
      lc_q <= lc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    emode_q <= emode_d;
    c_q <= c_d;
    e1_q <= e1_d;
    e2_q <= e2_d;
    necho_q <= necho_d;
    cols_q <= cols_d;
    acc_q <= acc_d;
    wake_q <= wake_d;
    intr_q <= intr_d;
    isrd_q <= isrd_d;
    rb_q <= rb_d;
  end

  logic [7:0] cin;
  logic full;
  logic [8:0] w;
  logic [9:0] csum;

  always_comb begin
    state_d = state_q;
    emode_d = emode_q;
    wp_d = wp_q; rp_d = rp_q; cp_d = cp_q;
    eof_d = eof_q; lc_d = lc_q;
    c_d = c_q; e1_d = e1_q; e2_d = e2_q; necho_d = necho_q;
    cols_d = cols_q; acc_d = acc_q; wake_d = wake_q;
    intr_d = intr_q; isrd_d = isrd_q; rb_d = rb_q;
    mem_we = 1'b0; mem_addr = rp_q; mem_wdata = c_q;
    result_valid_o = 1'b0;
    kind_o = KindStat; out_byte_o = '0; erase_columns_o = '0;
    accepted_o = 1'b0; wake_reader_o = 1'b0; lines_ready_o = lc_q; last_o = 1'b0;
    cin = (data_byte_i == ByteCr && canon_q) ? ByteLf : data_byte_i;
    full = (nxt(wp_q) == rp_q);
    w = is_ctrl(mem_rdata) ? 9'd2 : 9'd1;
    csum = {1'b0, cols_q} + {1'b0, w};

    case (state_q)
      StIdle: begin
        if (start_i) begin
          c_d = cin; necho_d = '0; cols_d = '0; acc_d = 1'b1; wake_d = 1'b0;
          intr_d = 1'b0; isrd_d = 1'b0;
          state_d = StEcho1;
          if (action_i) begin
            isrd_d = 1'b1;
            mem_addr = rp_q;
            if (rp_q != cp_q) state_d = StRdWait;
            else begin
              state_d = StStatus;
              if (eof_q) begin
                eof_d = 1'b0;
                rb_d = {5'd0, KindEof};
              end else rb_d = {5'd0, KindEmpty};
            end
          end else if (!canon_q) begin
            if (full) begin
              acc_d = 1'b0;
            end else begin
              mem_we = 1'b1; mem_addr = wp_q; mem_wdata = cin;
              wp_d = nxt(wp_q); cp_d = nxt(wp_q); eof_d = 1'b0; wake_d = 1'b1;
              necho_d = (echo_q && (cin == ByteLf || !is_ctrl(cin) || ctrl_q)) ?
                        3'd2 : 3'd0;
              if (cin == ByteLf) begin e1_d = ByteCr; e2_d = ByteLf; end
              else if (is_ctrl(cin)) begin
                e1_d = ByteCaret; e2_d = (cin == ByteDel) ? ByteQmark : cin + CaretOfs;
              end else begin necho_d = echo_q ? 3'd1 : 3'd0; e1_d = cin; end
            end
          end else begin
            case (cin)
              ByteLf: begin
                if (!full) begin
                  mem_we = 1'b1; mem_addr = wp_q; mem_wdata = ByteLf;
                  wp_d = nxt(wp_q); cp_d = nxt(wp_q); eof_d = 1'b0;
                  lc_d = lc_q + 8'd1; wake_d = 1'b1;
                  e1_d = ByteCr; e2_d = ByteLf; necho_d = echo_q ? 3'd2 : 3'd0;
                end
              end
              ByteBs, ByteDel, ByteWerase: begin
                if (wp_q == cp_q) begin
                  e1_d = ByteBell; necho_d = echo_q ? 3'd1 : 3'd0;
                end else begin
                  emode_d = (cin == ByteWerase) ? ErWordBlank : ErOne;
                  mem_addr = prv(wp_q);
                  state_d = StEraseChk;
                end
              end
              ByteKill, ByteIntr: begin
                intr_d = (cin == ByteIntr);
                if (wp_q != cp_q) begin
                  emode_d = ErKill;
                  mem_addr = prv(wp_q);
                  state_d = StEraseChk;
                end else state_d = StEraseOut;
              end
              ByteEof: begin
                if (wp_q == cp_q) eof_d = 1'b1;
                else begin
                  cp_d = wp_q; eof_d = 1'b0; lc_d = lc_q + 8'd1;
                end
                wake_d = 1'b1;
              end
              default: begin
                if (!full) begin
                  mem_we = 1'b1; mem_addr = wp_q; mem_wdata = cin;
                  wp_d = nxt(wp_q); eof_d = 1'b0;
                  if (is_ctrl(cin)) begin
                    e1_d = ByteCaret; e2_d = (cin == ByteDel) ? ByteQmark : cin + CaretOfs;
                    necho_d = (echo_q && ctrl_q) ? 3'd2 : 3'd0;
                  end else begin
                    e1_d = cin; necho_d = echo_q ? 3'd1 : 3'd0;
                  end
                end
              end
            endcase
          end
        end
      end
      StRdWait: begin
        rb_d = mem_rdata;
        rp_d = nxt(rp_q);
        if (canon_q && (mem_rdata == ByteLf || nxt(rp_q) == cp_q) && lc_q != 8'd0)
          lc_d = lc_q - 8'd1;
        // read byte beat is marked by intr_q
        intr_d = 1'b1;
        state_d = StStatus;
      end
      StEraseChk: begin
        // mem_rdata holds the byte just below wp_q
        if (emode_q == ErWordBlank && !is_blank(mem_rdata)) emode_d = ErWordText;
        if (emode_q == ErWordText && is_blank(mem_rdata)) begin
          state_d = StEraseOut;
        end else begin
          wp_d = prv(wp_q);
          cols_d = csum[9] ? ColsMax : csum[8:0];
          if (emode_q == ErOne || prv(wp_q) == cp_q) state_d = StEraseOut;
          else begin
            mem_addr = prv(prv(wp_q));
            state_d = StEraseChk;
          end
        end
      end
      StEraseOut: begin
        if (echo_q && cols_q != '0) begin
          result_valid_o = 1'b1; kind_o = KindErase; erase_columns_o = cols_q;
        end
        if (intr_q) begin
          e1_d = ByteCaret; e2_d = ByteIntr + CaretOfs;
          necho_d = echo_q ? (ctrl_q ? 3'd4 : 3'd2) : 3'd0;
          if (!ctrl_q) begin e1_d = ByteCr; e2_d = ByteLf; end
        end
        state_d = StEcho1;
      end
      StEcho1: begin
        if (necho_q == 3'd0) state_d = StStatus;
        else begin
          result_valid_o = 1'b1; kind_o = KindEcho; out_byte_o = e1_q;
          necho_d = necho_q - 3'd1;
          e1_d = e2_q;
          if (necho_q == 3'd4) e2_d = ByteCr;
          else if (necho_q == 3'd3) e2_d = ByteLf;
        end
      end
      StStatus: begin
        result_valid_o = 1'b1; last_o = 1'b1;
        if (isrd_q) begin
          if (intr_q) begin
            kind_o = KindRead; out_byte_o = rb_q;
          end else kind_o = rb_q[2:0];
        end else begin
          kind_o = KindStat; accepted_o = acc_q; wake_reader_o = wake_q;
        end
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

[hw/rtl/cle_ram.sv]
// ----------------------------------------------------------------------------
// cle_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[tb/canonical_line_editor_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// canonical_line_editor_checker
// Watches the command, config and result ports of the line editor, keeps
// its own copy of the ring, the pointers and the settings, works out the
// beats each accepted item must produce and compares them in order.
// ----------------------------------------------------------------------------
module canonical_line_editor_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  logic       action_i,
  input  logic [7:0] data_byte_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       result_valid_i,
  input  logic [2:0] kind_i,
  input  logic [7:0] out_byte_i,
  input  logic [8:0] erase_columns_i,
  input  logic       accepted_i,
  input  logic       wake_reader_i,
  input  logic [7:0] lines_ready_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         beats_due_o,
  output int         beats_seen_o
);

  import cle_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ob;
    logic [8:0] cols;
    logic       acc;
    logic       wake;
    logic [7:0] lines;
    logic       last;
  } beat_t;

  logic [7:0] ring [256];
  logic [7:0] wr_p, rd_p, cm_p, line_cnt;
  logic       eof_mark;
  logic       canon, echo_on, ctrl_on;

  beat_t step_beats[$];
  beat_t beats_due[$];

  function automatic logic ctrl_byte(input logic [7:0] c);
    return (c < ByteSpace && c != ByteTab) || c == ByteDel;
  endfunction

  function automatic logic blank_byte(input logic [7:0] c);
    return c == ByteSpace || c == ByteTab;
  endfunction

  function void add_beat(input kind_e k, input logic [7:0] b, input logic [8:0] cols,
                         input logic acc, input logic wake);
    beat_t t;
    t = '{kind: k, ob: b, cols: cols, acc: acc, wake: wake, lines: 8'd0, last: 1'b0};
    step_beats.push_back(t);
  endfunction

  function void echo_plain(input logic [7:0] c);
    if (!echo_on) return;
    if (c == ByteLf) add_beat(KindEcho, ByteCr, 9'd0, 1'b0, 1'b0);
    add_beat(KindEcho, c, 9'd0, 1'b0, 1'b0);
  endfunction

  function void echo_caret(input logic [7:0] c);
    if (!echo_on || !ctrl_on) return;
    add_beat(KindEcho, ByteCaret, 9'd0, 1'b0, 1'b0);
    add_beat(KindEcho, (c == ByteDel) ? ByteQmark : c + CaretOfs, 9'd0, 1'b0, 1'b0);
  endfunction

  function void echo_newline();
    if (!echo_on) return;
    add_beat(KindEcho, ByteCr, 9'd0, 1'b0, 1'b0);
    add_beat(KindEcho, ByteLf, 9'd0, 1'b0, 1'b0);
  endfunction

  function void echo_any(input logic [7:0] c);
    if (!echo_on) return;
    if (c == ByteLf) echo_newline();
    else if (ctrl_byte(c)) echo_caret(c);
    else echo_plain(c);
  endfunction

  function void rub_out(input int cols);
    if (!echo_on || cols == 0) return;
    add_beat(KindErase, 8'd0, (cols > 511) ? ColsMax : cols[8:0], 1'b0, 1'b0);
  endfunction

  function logic store_byte(input logic [7:0] c);
    if (wr_p + 8'd1 == rd_p) return 1'b0;
    ring[wr_p] = c;
    wr_p = wr_p + 8'd1;
    return 1'b1;
  endfunction

  function int drop_byte();
    if (wr_p == cm_p) return 0;
    wr_p = wr_p - 8'd1;
    return ctrl_byte(ring[wr_p]) ? 2 : 1;
  endfunction

  function int drop_line();
    int cols;
    cols = 0;
    while (wr_p != cm_p) cols += drop_byte();
    return cols;
  endfunction

  function void close_line();
    cm_p = wr_p;
    eof_mark = 1'b0;
    line_cnt = line_cnt + 8'd1;
  endfunction

  function void edit_put(input logic [7:0] c_in, output logic wake);
    logic [7:0] c;
    int cols;
    cols = 0;
    wake = 1'b0;
    c = (c_in == ByteCr) ? ByteLf : c_in;
    case (c)
      ByteLf: begin
        if (store_byte(ByteLf)) begin
          close_line();
          echo_newline();
          wake = 1'b1;
        end
      end
      ByteBs, ByteDel: begin
        if (wr_p == cm_p) echo_plain(ByteBell);
        else rub_out(drop_byte());
      end
      ByteKill: rub_out(drop_line());
      ByteWerase: begin
        if (wr_p == cm_p) echo_plain(ByteBell);
        else begin
          while (wr_p != cm_p && blank_byte(ring[wr_p - 8'd1])) cols += drop_byte();
          while (wr_p != cm_p && !blank_byte(ring[wr_p - 8'd1])) cols += drop_byte();
          rub_out(cols);
        end
      end
      ByteIntr: begin
        rub_out(drop_line());
        echo_caret(ByteIntr);
        echo_newline();
      end
      ByteEof: begin
        if (wr_p == cm_p) eof_mark = 1'b1;
        else close_line();
        wake = 1'b1;
      end
      default: begin
        if (store_byte(c)) begin
          eof_mark = 1'b0;
          echo_any(c);
        end
      end
    endcase
  endfunction

  function void discipline_step(input logic act, input logic [7:0] c);
    logic [7:0] b;
    logic wake, ok;
    step_beats.delete();
    if (act) begin
      if (rd_p != cm_p) begin
        b = ring[rd_p];
        rd_p = rd_p + 8'd1;
        if (canon && (b == ByteLf || rd_p == cm_p) && line_cnt > 0) line_cnt = line_cnt - 8'd1;
        add_beat(KindRead, b, 9'd0, 1'b0, 1'b0);
      end else if (eof_mark) begin
        eof_mark = 1'b0;
        add_beat(KindEof, 8'd0, 9'd0, 1'b0, 1'b0);
      end else begin
        add_beat(KindEmpty, 8'd0, 9'd0, 1'b0, 1'b0);
      end
    end else if (canon) begin
      edit_put(c, wake);
      add_beat(KindStat, 8'd0, 9'd0, 1'b1, wake);
    end else begin
      ok = store_byte(c);
      if (ok) begin
        cm_p = wr_p;
        eof_mark = 1'b0;
        echo_any(c);
      end
      add_beat(KindStat, 8'd0, 9'd0, ok, ok);
    end
    for (int k = 0; k < step_beats.size(); k++) begin
      step_beats[k].lines = line_cnt;
      step_beats[k].last = (k == step_beats.size() - 1);
      beats_due.push_back(step_beats[k]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t e;
    if (!rst_ni) begin
      wr_p = '0; rd_p = '0; cm_p = '0; line_cnt = '0;
      eof_mark = 1'b0;
      canon = 1'b1; echo_on = 1'b1; ctrl_on = 1'b1;
      beats_due.delete();
      fail_count_o <= 0;
      beats_due_o <= 0;
      beats_seen_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgCanon: canon = cfg_data_i[0];
          CfgEcho:  echo_on = cfg_data_i[0];
          CfgCtrl:  ctrl_on = cfg_data_i[0];
          default: ;
        endcase
      end
      if (result_valid_i) begin
        beats_seen_o <= beats_seen_o + 1;
        if (beats_due.size() == 0) begin
          $error("unexpected result beat kind=%0d", kind_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = beats_due.pop_front();
          if (kind_i !== e.kind || out_byte_i !== e.ob || erase_columns_i !== e.cols ||
              accepted_i !== e.acc || wake_reader_i !== e.wake ||
              lines_ready_i !== e.lines || last_i !== e.last) begin
            fail_count_o <= fail_count_o + 1;
            if (kind_i !== e.kind) $error("kind exp %0d got %0d", e.kind, kind_i);
            if (out_byte_i !== e.ob) $error("out_byte exp %h got %h", e.ob, out_byte_i);
            if (erase_columns_i !== e.cols)
              $error("erase_columns exp %0d got %0d", e.cols, erase_columns_i);
            if (accepted_i !== e.acc) $error("accepted exp %b got %b", e.acc, accepted_i);
            if (wake_reader_i !== e.wake)
              $error("wake_reader exp %b got %b", e.wake, wake_reader_i);
            if (lines_ready_i !== e.lines)
              $error("lines_ready exp %0d got %0d", e.lines, lines_ready_i);
            if (last_i !== e.last) $error("last exp %b got %b", e.last, last_i);
          end
        end
      end
      if (start_i && !busy_i) discipline_step(action_i, data_byte_i);
      beats_due_o <= beats_due.size();
    end
  end

endmodule

[tb/canonical_line_editor_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// canonical_line_editor_top_test
// Drives puts and reads into the line editor across canonical and raw mode
// and echo on and off with caret echo on and off, with random gaps, and reports the checker verdict.
// ----------------------------------------------------------------------------
module canonical_line_editor_top_test;
  import cle_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam logic [1:0] CfgNone = 2'd3;

  logic       clk, rst_n;
  logic       start, busy, action;
  logic [7:0] data_byte;
  logic       cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       res_valid, accepted, wake, last;
  logic [2:0] kind;
  logic [7:0] out_byte, lines;
  logic [8:0] cols;
  int         fails, due, seen, cycles, items;

  canonical_line_editor_top dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .action_i(action), .data_byte_i(data_byte),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .result_valid_o(res_valid), .kind_o(kind), .out_byte_o(out_byte),
    .erase_columns_o(cols), .accepted_o(accepted), .wake_reader_o(wake),
    .lines_ready_o(lines), .last_o(last)
  );

  canonical_line_editor_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .action_i(action), .data_byte_i(data_byte),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .result_valid_i(res_valid), .kind_i(kind), .out_byte_i(out_byte),
    .erase_columns_i(cols), .accepted_i(accepted), .wake_reader_i(wake),
    .lines_ready_i(lines), .last_i(last),
    .fail_count_o(fails), .beats_due_o(due), .beats_seen_o(seen)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send(input logic act, input logic [7:0] b);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    data_byte <= b;
    do @(posedge clk); while (busy);
    items++;
  endtask

  task automatic put(input logic [7:0] b);
    send(1'b0, b);
  endtask

  task automatic settle();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (due != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic c, input logic e, input logic k);
    settle();
    write_reg(CfgCanon, {7'($urandom_range(0, 127)), c});
    write_reg(CfgEcho, {7'($urandom_range(0, 127)), e});
    write_reg(CfgCtrl, {7'($urandom_range(0, 127)), k});
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'($urandom_range(8'h21, 8'h7e));
    if (r < 55) return $urandom_range(0, 1) ? ByteSpace : ByteTab;
    if (r < 75) begin
      case ($urandom_range(0, 5))
        0: return ByteBs;
        1: return ByteDel;
        2: return ByteKill;
        3: return ByteWerase;
        4: return ByteIntr;
        default: return ByteEof;
      endcase
    end
    if (r < 85) return $urandom_range(0, 1) ? ByteLf : ByteCr;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_lines(input int n);
    int len;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send(1'b1, 8'($urandom));
        continue;
      end
      len = $urandom_range(0, 8);
      for (int j = 0; j < len; j++) put(pick_byte());
      put($urandom_range(0, 4) == 0 ? ByteEof : ByteLf);
      len = $urandom_range(0, 12);
      for (int j = 0; j < len; j++) send(1'b1, 8'($urandom));
    end
  endtask

  initial begin
    clk = 1'b0; rst_n = 1'b0; cycles = 0; items = 0;
    start = 1'b0; action = 1'b0; data_byte = 8'd0;
    cfg_valid = 1'b0; cfg_index = 2'd0; cfg_data = 8'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed editing at reset settings
    send(1'b1, 8'hff);
    put(ByteBs); put(ByteWerase); put(ByteKill); put(ByteIntr);
    put(8'h61); put(8'h01); put(ByteTab); put(8'hff); put(8'h00);
    put(ByteBs); put(ByteDel);
    put(ByteSpace); put(8'h62); put(ByteSpace); put(ByteSpace); put(ByteWerase);
    put(8'h63); put(ByteKill); put(8'h64); put(ByteIntr);
    put(ByteEof); send(1'b1, 8'h00); send(1'b1, 8'h00);
    put(8'h7e); put(ByteEof); put(ByteCr); put(ByteLf);
    settle();
    repeat (6) send(1'b1, 8'h00);

    // sender holds off until all beats are in
    settle();
    random_lines(4);

    set_mode(1'b1, 1'b1, 1'b0);
    random_lines(3);
    set_mode(1'b1, 1'b0, 1'b1);
    random_lines(3);
    settle();
    write_reg(CfgNone, 8'h00);

    // pending bytes then switch to raw
    set_mode(1'b1, 1'b1, 1'b1);
    put(8'h41); put(8'h42);
    set_mode(1'b0, 1'b1, 1'b1);
    for (int i = 0; i < 20; i++) send($urandom_range(0, 2) == 0, 8'($urandom));

    set_mode(1'b1, 1'b1, 1'b1);
    random_lines(2);

    settle();
    $display("Covered %0d items and %0d result beats: canonical and raw mode,", items, seen);
    $display("all echo settings, line edits, EOF and reads of an empty store.");
    if (fails == 0 && due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/cle_pkg.sv
hw/rtl/cle_ram.sv
hw/rtl/canonical_line_editor_top.sv
tb/canonical_line_editor_checker.sv
tb/canonical_line_editor_top_test.sv
